### hdl/rtspf_pkg.sv
// ----------------------------------------------------------------------------
// rtspf_pkg
// Shared widths, character codes, status codes and control structs for the
// content-length response framer.
// ----------------------------------------------------------------------------
package rtspf_pkg;

   // widths of the body length and of the header byte counter
   localparam int LENGTH_BITS       = 32;
   localparam int HEADER_COUNT_BITS = 16;
   localparam int SIZE_BITS         = 33;

   // width wide enough for header count plus body length without loss
   localparam int WIDEST_BITS = (LENGTH_BITS > HEADER_COUNT_BITS) ?
                                LENGTH_BITS : HEADER_COUNT_BITS;
   localparam int SUM_BITS    = ((WIDEST_BITS > SIZE_BITS) ? WIDEST_BITS : SIZE_BITS) + 1;

   // length of the header name that carries the body length
   localparam logic [3:0] KEY_LEN = 4'd14;

   // character codes
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   // end of header: CR LF CR LF
   localparam logic [31:0] HEADER_TERMINATOR = 32'h0D0A0D0A;

   // per-beat status codes
   typedef enum logic [1:0] {
      STATUS_PENDING  = 2'd0,
      STATUS_COMPLETE = 2'd1,
      STATUS_ERROR    = 2'd2
   } frame_status_type;

   // control from the framer to the line parser
   typedef struct packed {
      logic step;     // header byte that is not the end of the header
      logic restart;  // message finished, parser back to line start
      logic prev_cr;  // previous byte of this message was CR
   } parse_ctrl_type;

   // what the line parser reports for the current byte
   typedef struct packed {
      logic set_length;  // a length line ended with a good value
      logic mark_bad;    // the length value is malformed
   } parse_event_type;

   // lower-case text of the length header name, one character per index
   function automatic logic [7:0] key_char(input logic [3:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd0:    c = 8'h63; // c
         4'd1:    c = 8'h6F; // o
         4'd2:    c = 8'h6E; // n
         4'd3:    c = 8'h74; // t
         4'd4:    c = 8'h65; // e
         4'd5:    c = 8'h6E; // n
         4'd6:    c = 8'h74; // t
         4'd7:    c = 8'h2D; // -
         4'd8:    c = 8'h6C; // l
         4'd9:    c = 8'h65; // e
         4'd10:   c = 8'h6E; // n
         4'd11:   c = 8'h67; // g
         4'd12:   c = 8'h74; // t
         4'd13:   c = 8'h68; // h
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

### hdl/rtspf_line_parser.sv
// ----------------------------------------------------------------------------
// rtspf_line_parser
// Walks one header line at a time: matches the name against the length
// header, then reads and checks the decimal value.
// ----------------------------------------------------------------------------
module rtspf_line_parser (
   input  logic                               clock,
   input  logic                               reset,
   input  rtspf_pkg::parse_ctrl_type          ctrl,
   input  logic [7:0]                         data_byte,
   output rtspf_pkg::parse_event_type         line_event,
   output logic [rtspf_pkg::LENGTH_BITS-1:0]  length_value
);

   typedef enum logic [2:0] {
      PH_NAME   = 3'd0,
      PH_SKIP   = 3'd1,
      PH_LEAD   = 3'd2,
      PH_DIGITS = 3'd3,
      PH_TRAIL  = 3'd4
   } line_phase_type;

   line_phase_type                       phase_ff, phase_in;
   logic [3:0]                           name_index_ff, name_index_in;
   logic                                 name_matches_ff, name_matches_in;
   logic [rtspf_pkg::LENGTH_BITS-1:0]    accum_ff, accum_in;

   logic [7:0]                           lower_byte;
   logic                                 is_digit;
   logic                                 is_blank;
   logic [rtspf_pkg::LENGTH_BITS+3:0]    accum_next;
   logic                                 accum_ovf;

   // byte classification
   assign is_digit = (data_byte >= rtspf_pkg::CHAR_ZERO) && (data_byte <= rtspf_pkg::CHAR_NINE);
   assign is_blank = (data_byte == rtspf_pkg::CHAR_SPACE) || (data_byte == rtspf_pkg::CHAR_TAB);
   assign lower_byte = ((data_byte >= rtspf_pkg::CHAR_UPPER_A) &&
                        (data_byte <= rtspf_pkg::CHAR_UPPER_Z)) ?
                       data_byte + rtspf_pkg::CASE_OFFSET : data_byte;

   // accum * 10 + digit, overflow when any bit above the length width is set
   assign accum_next = {accum_ff, 3'b000} + {2'b00, accum_ff, 1'b0}
                     + {{rtspf_pkg::LENGTH_BITS{1'b0}}, data_byte[3:0]};
   assign accum_ovf  = |accum_next[rtspf_pkg::LENGTH_BITS+3:rtspf_pkg::LENGTH_BITS];

   assign length_value = accum_ff;

   // next line state for this byte
   always_comb begin
      phase_in        = phase_ff;
      name_index_in   = name_index_ff;
      name_matches_in = name_matches_ff;
      accum_in        = accum_ff;
      line_event      = '0;

      if ((data_byte == rtspf_pkg::CHAR_LF) && ctrl.prev_cr) begin
         // line end: judge the value, then back to the name
         if (phase_ff == PH_LEAD) begin
            line_event.mark_bad = 1'b1;
         end
         if ((phase_ff == PH_DIGITS) || (phase_ff == PH_TRAIL)) begin
            line_event.set_length = 1'b1;
         end
         phase_in        = PH_NAME;
         name_index_in   = '0;
         name_matches_in = 1'b1;
         accum_in        = '0;
      end else begin
         unique case (phase_ff)
            PH_NAME: begin
               if (data_byte == rtspf_pkg::CHAR_COLON) begin
                  if (name_matches_ff && (name_index_ff == rtspf_pkg::KEY_LEN)) begin
                     phase_in = PH_LEAD;
                     accum_in = '0;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end else if ((name_index_ff < rtspf_pkg::KEY_LEN) &&
                            (lower_byte == rtspf_pkg::key_char(name_index_ff))) begin
                  name_index_in = name_index_ff + 4'd1;
               end else begin
                  name_matches_in = 1'b0;
               end
            end
            PH_SKIP: begin
            end
            PH_LEAD, PH_DIGITS, PH_TRAIL: begin
               // a CR not followed by LF is a stray character
               if (ctrl.prev_cr) begin
                  line_event.mark_bad = 1'b1;
               end
               if (data_byte == rtspf_pkg::CHAR_CR) begin
               end else if (is_blank) begin
                  if (phase_ff == PH_DIGITS) begin
                     phase_in = PH_TRAIL;
                  end
               end else if (is_digit && (phase_ff != PH_TRAIL)) begin
                  if (accum_ovf) begin
                     line_event.mark_bad = 1'b1;
                     accum_in = '0;
                  end else begin
                     accum_in = accum_next[rtspf_pkg::LENGTH_BITS-1:0];
                  end
                  phase_in = PH_DIGITS;
               end else begin
                  line_event.mark_bad = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // line state registers
   always_ff @(posedge clock) begin
      if (reset || ctrl.restart) begin
         phase_ff        <= PH_NAME;
         name_index_ff   <= '0;
         name_matches_ff <= 1'b1;
         accum_ff        <= '0;
      end else if (ctrl.step) begin
         phase_ff        <= phase_in;
         name_index_ff   <= name_index_in;
         name_matches_ff <= name_matches_in;
         accum_ff        <= accum_in;
      end
   end

endmodule

### hdl/rtsp_response_framer.sv
// ----------------------------------------------------------------------------
// rtsp_response_framer: one status beat per byte, result registered in the cycle after accept
// Throughput one byte per cycle; req_ready drops only while a result is held
// and rsp_ready is low. Synchronous active-high reset starts a fresh message.
// ----------------------------------------------------------------------------
module rtsp_response_framer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_data_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_frame_status,
   output logic [rtspf_pkg::SIZE_BITS-1:0]    rsp_message_size
);

   logic [23:0]                                recent_ff, recent_in;
   logic                                       in_body_ff, in_body_in;
   logic [rtspf_pkg::HEADER_COUNT_BITS-1:0]    header_count_ff, header_count_in;
   logic [rtspf_pkg::LENGTH_BITS-1:0]          found_length_ff, found_length_in;
   logic                                       header_bad_ff, header_bad_in;
   logic [rtspf_pkg::LENGTH_BITS-1:0]          body_rem_ff, body_rem_in;

   logic                                       rsp_valid_ff, rsp_valid_in;
   rtspf_pkg::frame_status_type                rsp_status_ff, rsp_status_in;
   logic [rtspf_pkg::SIZE_BITS-1:0]            rsp_size_ff, rsp_size_in;

   logic                                       accept;
   logic                                       restart;
   logic [31:0]                                window;
   logic [rtspf_pkg::LENGTH_BITS-1:0]          body_rem_dec;
   logic [rtspf_pkg::SUM_BITS-1:0]             body_total;
   logic [rtspf_pkg::SUM_BITS-1:0]             header_total;
   rtspf_pkg::parse_ctrl_type                  parse_ctrl;
   rtspf_pkg::parse_event_type                 parse_event;
   logic [rtspf_pkg::LENGTH_BITS-1:0]          parse_length;

   // handshake: output register frees when empty or being taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_status = rsp_status_ff;
   assign rsp_message_size = rsp_size_ff;

   // byte history and size arithmetic
   assign window       = {recent_ff, req_data_byte};
   assign body_rem_dec = body_rem_ff - rtspf_pkg::LENGTH_BITS'(body_rem_ff != '0);
   assign body_total   = rtspf_pkg::SUM_BITS'(header_count_ff)
                       + rtspf_pkg::SUM_BITS'(found_length_ff);
   assign header_total = rtspf_pkg::SUM_BITS'(header_count_ff)
                       + rtspf_pkg::SUM_BITS'(1'b1);

   // header line parser
   rtspf_line_parser u_line_parser (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (parse_ctrl),
      .data_byte    (req_data_byte),
      .line_event   (parse_event),
      .length_value (parse_length)
   );

   // per-beat message tracking
   always_comb begin
      recent_in       = recent_ff;
      in_body_in      = in_body_ff;
      header_count_in = header_count_ff;
      found_length_in = found_length_ff;
      header_bad_in   = header_bad_ff;
      body_rem_in     = body_rem_ff;
      restart         = 1'b0;
      parse_ctrl      = '0;
      rsp_status_in   = rsp_status_ff;
      rsp_size_in     = rsp_size_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;

      parse_ctrl.prev_cr = (recent_ff[7:0] == rtspf_pkg::CHAR_CR);

      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = rtspf_pkg::STATUS_PENDING;
         rsp_size_in   = '0;
         if (in_body_ff) begin
            // body bytes are only counted
            body_rem_in = body_rem_dec;
            if (body_rem_dec == '0) begin
               rsp_status_in = rtspf_pkg::STATUS_COMPLETE;
               rsp_size_in   = body_total[rtspf_pkg::SIZE_BITS-1:0];
               restart       = 1'b1;
            end
         end else if (&header_count_ff) begin
            // header over the size limit
            rsp_status_in = rtspf_pkg::STATUS_ERROR;
            restart       = 1'b1;
         end else begin
            header_count_in = header_count_ff + 1'b1;
            recent_in       = window[23:0];
            if (window == rtspf_pkg::HEADER_TERMINATOR) begin
               // end of header: error, done, or on to the body
               if (header_bad_ff) begin
                  rsp_status_in = rtspf_pkg::STATUS_ERROR;
                  restart       = 1'b1;
               end else if (found_length_ff == '0) begin
                  rsp_status_in = rtspf_pkg::STATUS_COMPLETE;
                  rsp_size_in   = header_total[rtspf_pkg::SIZE_BITS-1:0];
                  restart       = 1'b1;
               end else begin
                  in_body_in  = 1'b1;
                  body_rem_in = found_length_ff;
               end
            end else begin
               parse_ctrl.step = 1'b1;
               if (parse_event.mark_bad) begin
                  header_bad_in = 1'b1;
               end
               if (parse_event.set_length) begin
                  found_length_in = parse_length;
               end
            end
         end
      end

      parse_ctrl.restart = restart;
   end

   // message state
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         recent_ff       <= '0;
         in_body_ff      <= 1'b0;
         header_count_ff <= '0;
         found_length_ff <= '0;
         header_bad_ff   <= 1'b0;
         body_rem_ff     <= '0;
      end else begin
         recent_ff       <= recent_in;
         in_body_ff      <= in_body_in;
         header_count_ff <= header_count_in;
         found_length_ff <= found_length_in;
         header_bad_ff   <= header_bad_in;
         body_rem_ff     <= body_rem_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_size_ff   <= rsp_size_in;
   end

endmodule

### hdl/rtspf_checker.sv
// ----------------------------------------------------------------------------
// rtspf_checker
// Port-level checks for the response framer, bound to the top level.
// ----------------------------------------------------------------------------
module rtspf_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [1:0]                         rsp_frame_status,
   input logic [rtspf_pkg::SIZE_BITS-1:0]    rsp_message_size
);

   // every accepted byte gives a result beat on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted byte produced no result beat");

   // an empty result register never holds off the input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with no result pending");

   // a complete message covers at least the header terminator
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_frame_status == rtspf_pkg::STATUS_COMPLETE)
         |-> (rsp_message_size >= rtspf_pkg::SIZE_BITS'(4)))
      else $error("complete message shorter than the terminator");

   // size is zero unless the message is complete
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_frame_status != rtspf_pkg::STATUS_COMPLETE)
         |-> (rsp_message_size == '0))
      else $error("size reported on a non-complete beat");

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready
         |=> rsp_valid && $stable(rsp_frame_status) && $stable(rsp_message_size))
      else $error("stalled result beat changed");

endmodule

bind rtsp_response_framer rtspf_checker u_rtspf_checker (.*);
